// ===== hw/rtl/rrld_pkg.sv =====
`timescale 1ns / 1ps

package rrld_pkg;

  // field widths
  localparam int unsigned GateCountW   = 11;
  localparam int unsigned RadialCountW = 10;
  localparam int unsigned StepW        = 12;
  localparam int unsigned AzW          = 16;
  localparam int unsigned RowW         = 9;
  localparam int unsigned GateW        = 11;
  localparam int unsigned GateIdxW     = 10;
  localparam int unsigned RunLeftW     = 17;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned CfgDataW     = 12;

  // product limits
  localparam int unsigned MaxGates   = 1024;
  localparam int unsigned MaxRadials = 512;

  // azimuth wrap in tenths of a degree
  localparam logic [AzW-1:0] AzWrap = 16'd3600;

  // gate position saturation
  localparam logic [GateW-1:0] GateSat = 11'd2047;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgGateCount   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRadialCount = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgAzStep      = 2'd2;

  // configuration reset values
  localparam logic [GateCountW-1:0]   GateCountRst   = 11'd460;
  localparam logic [RadialCountW-1:0] RadialCountRst = 10'd360;
  localparam logic [StepW-1:0]        AzStepRst      = 12'd10;

  typedef enum logic [2:0] {
    PhIdle,
    PhNumHi,
    PhNumLo,
    PhAzHi,
    PhAzLo,
    PhDazHi,
    PhDazLo,
    PhRuns
  } phase_e;

  typedef enum logic [1:0] {
    StReady,
    StDiv,
    StEmit
  } state_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_req_t;

  typedef struct packed {
    logic [RowW-1:0]     radial_index;
    logic [GateIdxW-1:0] gate_index;
    logic [3:0]          level_code;
    logic                overflow;
    logic                last;
  } out_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [AzW-1:0]   quot;
    logic [StepW-1:0] rem;
  } div_res_t;

endpackage

// ===== hw/rtl/rrld_div.sv =====
`timescale 1ns / 1ps

module rrld_div import rrld_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [AzW-1:0]   dividend_i,
  input  logic [StepW-1:0] divisor_i,
  output div_res_t         res_o
);

  localparam int unsigned CntW = $clog2(AzW);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [AzW-1:0]   quo_q, quo_d;
  logic [StepW-1:0] rem_q, rem_d;
  logic [StepW-1:0] div_q, div_d;
  logic [StepW:0]   rem_sh;
  logic [StepW:0]   diff;

  // one restoring step: shift in next dividend bit, trial subtract
  always_comb begin
    rem_sh = {rem_q, quo_q[AzW-1]};
    diff   = rem_sh - {1'b0, div_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(AzW - 1);
      quo_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, div_q}) begin
        rem_d = diff[StepW-1:0];
        quo_d = {quo_q[AzW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[StepW-1:0];
        quo_d = {quo_q[AzW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign res_o.busy = busy_q;
  assign res_o.done = done_q;
  assign res_o.quot = quo_q;
  assign res_o.rem  = rem_q;

endmodule

// ===== hw/rtl/radial_run_length_decoder_core.sv =====
// header and delta azimuth bytes do not stall the input; the azimuth low byte stalls it while
// the 16-step radix-2 divider turns the azimuth into a row (no division when the step is zero).
// a run byte with a nonzero repeat count (up to 15) stalls the input while the emitter makes one gate
// write per cycle through the output register; a full output register holds the emitter.
// reset is asynchronous, active low: parser idle, counters zero, configuration registers at defaults.
`timescale 1ns / 1ps

module radial_run_length_decoder_core import rrld_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_req_t            in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_req_t           out_req_o
);

  // configuration registers
  logic [GateCountW-1:0]   gate_count_q;
  logic [RadialCountW-1:0] radial_count_q;
  logic [StepW-1:0]        az_step_q;

  // parser and engine state
  state_e                  state_q, state_d;
  phase_e                  phase_q, phase_d;
  logic [7:0]              hold_q, hold_d;
  logic [RunLeftW-1:0]     run_left_q, run_left_d;
  logic [RowW-1:0]         row_q, row_d;
  logic [GateW-1:0]        next_gate_q, next_gate_d;
  logic [RadialCountW-1:0] rad_left_q, rad_left_d;
  logic [GateW-1:0]        emit_gate_q, emit_gate_d;
  logic [3:0]              reps_left_q, reps_left_d;
  logic [3:0]              level_q, level_d;
  logic                    out_valid_q, out_valid_d;
  out_req_t                out_req_q, out_req_d;

  // divider interface
  logic                    div_start;
  logic [AzW-1:0]          div_dividend;
  div_res_t                div_res;

  // derived limits
  logic [GateCountW-1:0]   gate_lim;
  logic [RadialCountW-1:0] rad_lim;
  logic [RadialCountW-1:0] top_row;

  // row rounding
  logic [StepW:0]          rem_x2;
  logic                    round_up;
  logic [AzW:0]            quot_r;
  logic [RowW-1:0]         row_calc;

  logic                    in_acc;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != StReady);

  always_comb begin
    gate_lim = (int'(gate_count_q) > MaxGates) ? GateCountW'(MaxGates) : gate_count_q;
    rad_lim  = (int'(radial_count_q) > MaxRadials) ? RadialCountW'(MaxRadials)
                                                   : radial_count_q;
    top_row  = (rad_lim == '0) ? '0 : rad_lim - 1'b1;
  end

  // round half to even, then clamp to the last row
  always_comb begin
    rem_x2   = {div_res.rem, 1'b0};
    round_up = (rem_x2 > {1'b0, az_step_q}) ||
               ((rem_x2 == {1'b0, az_step_q}) && div_res.quot[0]);
    quot_r   = {1'b0, div_res.quot} + (AzW+1)'(round_up);
    if (quot_r > (AzW+1)'(top_row)) begin
      row_calc = top_row[RowW-1:0];
    end else begin
      row_calc = quot_r[RowW-1:0];
    end
  end

  rrld_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (az_step_q),
    .res_o      (div_res)
  );

  // sequencer: byte parsing, divider hand-off and gate emission
  always_comb begin
    phase_e                  ph;
    logic [RadialCountW-1:0] rl;
    logic [GateW-1:0]        ng;
    logic [RunLeftW-1:0]     rbl;
    logic [RunLeftW-1:0]     rbl_dec;
    logic [AzW-1:0]          az;
    logic [GateW:0]          gate_sum;
    logic [RadialCountW-1:0] rl_end;
    logic                    ovf;

    state_d      = state_q;
    phase_d      = phase_q;
    hold_d       = hold_q;
    run_left_d   = run_left_q;
    row_d        = row_q;
    next_gate_d  = next_gate_q;
    rad_left_d   = rad_left_q;
    emit_gate_d  = emit_gate_q;
    reps_left_d  = reps_left_q;
    level_d      = level_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_req_d    = out_req_q;
    div_start    = 1'b0;

    // frame start restarts the parser
    ph  = phase_q;
    rl  = rad_left_q;
    ng  = next_gate_q;
    rbl = run_left_q;
    if (in_req_i.frame_start) begin
      rl  = rad_lim;
      ng  = '0;
      rbl = '0;
      ph  = (rad_lim != '0) ? PhNumHi : PhIdle;
    end
    rbl_dec  = rbl - 1'b1;
    az       = {hold_q, in_req_i.data_byte};
    div_dividend = (az >= AzWrap) ? az - AzWrap : az;
    gate_sum = {1'b0, ng} + (GateW+1)'(in_req_i.data_byte[7:4]);
    rl_end   = (rl != '0) ? rl - 1'b1 : rl;
    ovf      = (emit_gate_q >= gate_lim);

    case (state_q)
      StReady: begin
        if (in_acc) begin
          rad_left_d  = rl;
          next_gate_d = ng;
          run_left_d  = rbl;
          phase_d     = ph;
          case (ph)
            PhIdle: begin
            end
            PhNumHi: begin
              hold_d  = in_req_i.data_byte;
              phase_d = PhNumLo;
            end
            PhNumLo: begin
              run_left_d = {hold_q, in_req_i.data_byte, 1'b0};
              phase_d    = PhAzHi;
            end
            PhAzHi: begin
              hold_d  = in_req_i.data_byte;
              phase_d = PhAzLo;
            end
            PhAzLo: begin
              phase_d = PhDazHi;
              if (az_step_q == '0) begin
                row_d = top_row[RowW-1:0];
              end else begin
                div_start = 1'b1;
                state_d   = StDiv;
              end
            end
            PhDazHi: begin
              phase_d = PhDazLo;
            end
            PhDazLo: begin
              next_gate_d = '0;
              if (rbl == '0) begin
                rad_left_d = rl_end;
                phase_d    = (rl_end == '0) ? PhIdle : PhNumHi;
              end else begin
                phase_d = PhRuns;
              end
            end
            PhRuns: begin
              emit_gate_d = ng;
              reps_left_d = in_req_i.data_byte[7:4];
              level_d     = in_req_i.data_byte[3:0];
              if (in_req_i.data_byte[7:4] != '0) begin
                state_d = StEmit;
              end
              run_left_d = rbl_dec;
              if (gate_sum > (GateW+1)'(GateSat)) begin
                next_gate_d = GateSat;
              end else begin
                next_gate_d = gate_sum[GateW-1:0];
              end
              if (rbl_dec == '0) begin
                next_gate_d = '0;
                rad_left_d  = rl_end;
                phase_d     = (rl_end == '0) ? PhIdle : PhNumHi;
              end
            end
            default: begin
            end
          endcase
        end
      end
      StDiv: begin
        if (div_res.done) begin
          row_d   = row_calc;
          state_d = StReady;
        end
      end
      StEmit: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d            = 1'b1;
          out_req_d.radial_index = row_q;
          out_req_d.gate_index   = ovf ? '0 : emit_gate_q[GateIdxW-1:0];
          out_req_d.level_code   = level_q;
          out_req_d.overflow     = ovf;
          out_req_d.last         = (reps_left_q == 4'd1);
          reps_left_d            = reps_left_q - 1'b1;
          if (emit_gate_q < GateSat) begin
            emit_gate_d = emit_gate_q + 1'b1;
          end
          if (reps_left_q == 4'd1) begin
            state_d = StReady;
          end
        end
      end
      default: begin
        state_d = StReady;
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_count_q   <= GateCountRst;
      radial_count_q <= RadialCountRst;
      az_step_q      <= AzStepRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgGateCount:   gate_count_q   <= cfg_data_i[GateCountW-1:0];
        CfgRadialCount: radial_count_q <= cfg_data_i[RadialCountW-1:0];
        CfgAzStep:      az_step_q      <= cfg_data_i[StepW-1:0];
        default: begin
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StReady;
      phase_q     <= PhIdle;
      hold_q      <= '0;
      run_left_q  <= '0;
      row_q       <= '0;
      next_gate_q <= '0;
      rad_left_q  <= '0;
      emit_gate_q <= '0;
      reps_left_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      hold_q      <= hold_d;
      run_left_q  <= run_left_d;
      row_q       <= row_d;
      next_gate_q <= next_gate_d;
      rad_left_q  <= rad_left_d;
      emit_gate_q <= emit_gate_d;
      reps_left_q <= reps_left_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    level_q   <= level_d;
    out_req_q <= out_req_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

  // a new gate write only comes from the emitter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == StEmit))
    else $error("output request appeared outside emission");

  // the emitter never runs with no repeats left
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StEmit |-> reps_left_q != '0)
    else $error("emission with zero repeats left");

  // dropped gates carry gate index zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.overflow |-> out_req_o.gate_index == '0)
    else $error("overflow request with nonzero gate index");

  // the divider finishes only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.done |-> state_q == StDiv)
    else $error("divider result with no division pending");

endmodule
